>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers, clocked on clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// plain property check
`define CLAC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// same-cycle implication
`define CLAC_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// next-cycle implication
`define CLAC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define CLAC_ASSERT(lbl, prop, msg)
`define CLAC_ASSERT_IMP(lbl, ante, cons, msg)
`define CLAC_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

>>> sv/clac_pkg.sv
// ----------------------------------------------------------------------------
// clac_pkg
// Types and constants for the cache line access counter.
// ----------------------------------------------------------------------------
`default_nettype none

package clac_pkg;

    localparam int ADDR_W   = 48;
    localparam int CNT_W    = 32;
    localparam int SIZE_W   = 7;
    localparam int CMD_W    = 2;
    localparam int LS_W     = 4;
    localparam int LS_MAX   = 12;
    localparam int LS_RESET = 6;

    localparam int DEF_ENTRIES     = 64;
    localparam int DEF_GRANULARITY = 4;
    localparam int DEF_MAX_ACCESS  = 64;

    localparam logic [CMD_W-1:0] CMD_READ  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_END   = 2'd2;

    // one table entry as it moves between cells
    typedef struct packed {
        logic [ADDR_W-1:0] tag;
        logic [CNT_W-1:0]  rd;
        logic [CNT_W-1:0]  wr;
    } entry_t;

    // broadcast control from the sequencer to every cell
    typedef struct packed {
        logic [ADDR_W-1:0] key;
        logic              is_write;
        logic              step_en;
        logic              shift_en;
        logic              any_hit;
    } cell_ctrl_t;

endpackage

`default_nettype wire

>>> sv/clac_cell.sv
// ----------------------------------------------------------------------------
// clac_cell
// One table slot: tag compare, saturating counters, append and dump shift.
// ----------------------------------------------------------------------------
`default_nettype none

module clac_cell (
    input  wire                 clk,
    input  wire clac_pkg::cell_ctrl_t ctrl,
    input  wire                 ent_valid,
    input  wire                 ent_tail,
    input  wire clac_pkg::entry_t nb,
    output clac_pkg::entry_t    ent,
    output logic                hit
);
    import clac_pkg::*;

    entry_t ent_reg;
    entry_t ent_next;

    assign hit = ent_valid && (ent_reg.tag == ctrl.key);
    assign ent = ent_reg;

    always_comb
    begin
        ent_next = ent_reg;
        if (ctrl.shift_en)
        begin
            // dump: take the entry of the next cell up
            ent_next = nb;
        end
        else if (ctrl.step_en)
        begin
            if (hit)
            begin
                if (ctrl.is_write)
                begin
                    if (ent_reg.wr != {CNT_W{1'b1}})
                        ent_next.wr = ent_reg.wr + CNT_W'(1);
                end
                else
                begin
                    if (ent_reg.rd != {CNT_W{1'b1}})
                        ent_next.rd = ent_reg.rd + CNT_W'(1);
                end
            end
            else if (ent_tail && !ctrl.any_hit)
            begin
                ent_next.tag = ctrl.key;
                ent_next.rd  = ctrl.is_write ? CNT_W'(0) : CNT_W'(1);
                ent_next.wr  = ctrl.is_write ? CNT_W'(1) : CNT_W'(0);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg <= ent_next;
    end

endmodule

`default_nettype wire

>>> sv/cache_line_access_counter_top.sv
// ----------------------------------------------------------------------------
// cache_line_access_counter_top
// Per cache line read/write access profiler built on a row of table cells.
// ----------------------------------------------------------------------------
// One request at a time. A read or write request walks its bytes in
// GRANULARITY steps, one table update per cycle: all cells compare the aligned
// line in parallel, a hit bumps that cell's counter and a miss appends at the
// fill position, or sets the drop status when the table is full. An access
// of S bytes (clamped to MAX_ACCESS_BYTES, at most 127) is walked in
// ceil(S / GRANULARITY) table updates, so 16 for 64 bytes in 4-byte steps,
// after acceptance and before the end of the walk and the result load.
// End region streams the table out of cell 0 while the row shifts down one
// cell per cycle: one result per entry per cycle while the output is not
// stalled. No clearing pass is needed after reset.
`default_nettype none

`include "assert_macros.svh"

module cache_line_access_counter_top #(
    parameter int ENTRIES          = clac_pkg::DEF_ENTRIES,
    parameter int GRANULARITY      = clac_pkg::DEF_GRANULARITY,
    parameter int MAX_ACCESS_BYTES = clac_pkg::DEF_MAX_ACCESS
) (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            cfg_wen,
    input  wire  [clac_pkg::LS_W-1:0]      cfg_wdata,
    input  wire                            in_valid,
    output logic                           in_stall,
    input  wire  [clac_pkg::CMD_W-1:0]     cmd,
    input  wire  [clac_pkg::ADDR_W-1:0]    access_address,
    input  wire  [clac_pkg::SIZE_W-1:0]    access_size,
    output logic                           out_valid,
    input  wire                            out_stall,
    output logic                           status,
    output logic                           entry_valid,
    output logic [clac_pkg::ADDR_W-1:0]    line_address,
    output logic [clac_pkg::CNT_W-1:0]     read_total,
    output logic [clac_pkg::CNT_W-1:0]     write_total,
    output logic [clac_pkg::CNT_W-1:0]     epoch,
    output logic                           last
);
    import clac_pkg::*;

    localparam int FILL_W = $clog2(ENTRIES + 1);
    localparam int CLAMP  = (MAX_ACCESS_BYTES > 127) ? 127 : MAX_ACCESS_BYTES;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_STEP = 2'd1;
    localparam logic [1:0] S_DUMP = 2'd2;
    localparam logic [1:0] S_FIN  = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [LS_W-1:0]   ls_reg;
    logic [FILL_W-1:0] fill_reg, fill_next;
    logic [CNT_W-1:0]  epoch_reg, epoch_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [SIZE_W-1:0] rem_reg, rem_next;
    logic              wr_reg, wr_next;
    logic              drop_reg, drop_next;

    logic              out_valid_reg, out_valid_next;
    logic              status_reg, status_next;
    logic              entry_valid_reg, entry_valid_next;
    logic [ADDR_W-1:0] line_reg, line_next;
    logic [CNT_W-1:0]  rd_reg, rd_next;
    logic [CNT_W-1:0]  wt_reg, wt_next;
    logic [CNT_W-1:0]  ep_reg, ep_next;
    logic              last_reg, last_next;

    cell_ctrl_t        ctrl;
    entry_t            ent [ENTRIES];
    logic [ENTRIES-1:0] hit_vec;
    logic [LS_W-1:0]   ls_eff;
    logic [ADDR_W-1:0] line_mask;
    logic [SIZE_W-1:0] size_eff;
    logic              can_load;
    logic              in_acc;
    logic              full;

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid && !in_stall;
    assign can_load = !out_valid_reg || !out_stall;
    assign full     = (fill_reg == FILL_W'(ENTRIES));

    assign ls_eff    = (ls_reg > LS_W'(LS_MAX)) ? LS_W'(LS_MAX) : ls_reg;
    assign line_mask = ~((ADDR_W'(1) << ls_eff) - ADDR_W'(1));
    assign size_eff  = (access_size > SIZE_W'(CLAMP)) ? SIZE_W'(CLAMP) : access_size;

    always_comb
    begin
        ctrl.key      = addr_reg & line_mask;
        ctrl.is_write = wr_reg;
        ctrl.step_en  = (state_reg == S_STEP) && (rem_reg != '0);
        ctrl.shift_en = (state_reg == S_DUMP) && can_load && (fill_reg != '0);
        ctrl.any_hit  = |hit_vec;
    end

    generate
        for (genvar i = 0; i < ENTRIES; i++)
        begin : g_cell
            entry_t nb_ent;
            if (i == ENTRIES - 1)
            begin : g_end
                assign nb_ent = ent[i];
            end
            else
            begin : g_mid
                assign nb_ent = ent[i+1];
            end
            clac_cell u_cell (
                .clk       (clk),
                .ctrl      (ctrl),
                .ent_valid (fill_reg > FILL_W'(i)),
                .ent_tail  (fill_reg == FILL_W'(i)),
                .nb        (nb_ent),
                .ent       (ent[i]),
                .hit       (hit_vec[i])
            );
        end
    endgenerate

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        fill_next  = fill_reg;
        epoch_next = epoch_reg;
        addr_next  = addr_reg;
        rem_next   = rem_reg;
        wr_next    = wr_reg;
        drop_next  = drop_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    addr_next = access_address;
                    rem_next  = size_eff;
                    wr_next   = (cmd == CMD_WRITE);
                    drop_next = 1'b0;
                    if (cmd == CMD_READ || cmd == CMD_WRITE)
                        state_next = S_STEP;
                    else if (cmd == CMD_END)
                        state_next = S_DUMP;
                    else
                        state_next = S_FIN;
                end
            end
            S_STEP:
            begin
                if (rem_reg == '0)
                begin
                    state_next = S_FIN;
                end
                else
                begin
                    addr_next = addr_reg + ADDR_W'(GRANULARITY);
                    rem_next  = (rem_reg > SIZE_W'(GRANULARITY))
                              ? rem_reg - SIZE_W'(GRANULARITY) : '0;
                    if (!ctrl.any_hit)
                    begin
                        if (full)
                            drop_next = 1'b1;
                        else
                            fill_next = fill_reg + FILL_W'(1);
                    end
                end
            end
            S_DUMP:
            begin
                if (can_load)
                begin
                    if (fill_reg != '0)
                        fill_next = fill_reg - FILL_W'(1);
                    if (fill_reg <= FILL_W'(1))
                    begin
                        epoch_next = epoch_reg + CNT_W'(1);
                        state_next = S_IDLE;
                    end
                end
            end
            S_FIN:
            begin
                if (can_load)
                    state_next = S_IDLE;
            end
        endcase
    end

    // output register
    always_comb
    begin
        out_valid_next   = out_valid_reg && out_stall;
        status_next      = status_reg;
        entry_valid_next = entry_valid_reg;
        line_next        = line_reg;
        rd_next          = rd_reg;
        wt_next          = wt_reg;
        ep_next          = ep_reg;
        last_next        = last_reg;
        if (can_load && (state_reg == S_FIN || state_reg == S_DUMP))
        begin
            out_valid_next   = 1'b1;
            status_next      = 1'b0;
            entry_valid_next = 1'b0;
            line_next        = '0;
            rd_next          = '0;
            wt_next          = '0;
            ep_next          = epoch_reg;
            last_next        = 1'b1;
            if (state_reg == S_FIN)
            begin
                status_next = drop_reg;
            end
            else if (fill_reg != '0)
            begin
                entry_valid_next = 1'b1;
                line_next        = ent[0].tag;
                rd_next          = ent[0].rd;
                wt_next          = ent[0].wr;
                last_next        = (fill_reg == FILL_W'(1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ls_reg        <= LS_W'(LS_RESET);
            fill_reg      <= '0;
            epoch_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            epoch_reg     <= epoch_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen)
                ls_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg        <= addr_next;
        rem_reg         <= rem_next;
        wr_reg          <= wr_next;
        drop_reg        <= drop_next;
        status_reg      <= status_next;
        entry_valid_reg <= entry_valid_next;
        line_reg        <= line_next;
        rd_reg          <= rd_next;
        wt_reg          <= wt_next;
        ep_reg          <= ep_next;
        last_reg        <= last_next;
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign entry_valid  = entry_valid_reg;
    assign line_address = line_reg;
    assign read_total   = rd_reg;
    assign write_total  = wt_reg;
    assign epoch        = ep_reg;
    assign last         = last_reg;

    // tags are unique, so a line matches at most one cell
    `CLAC_ASSERT(a_one_hit, $onehot0(hit_vec), "more than one cell matched a line")
    `CLAC_ASSERT(a_fill_range, fill_reg <= FILL_W'(ENTRIES), "fill level beyond table size")
    `CLAC_ASSERT_NXT(a_dump_drain, ctrl.shift_en, fill_reg == $past(fill_reg) - FILL_W'(1), "dump did not drain one entry")
    `CLAC_ASSERT_NXT(a_epoch_step, state_reg == S_DUMP && state_next == S_IDLE, epoch_reg == $past(epoch_reg) + CNT_W'(1), "epoch not advanced at region end")

endmodule

`default_nettype wire
